// File: rtl/wcsr_pkg.sv
// Shared types, widths and constants of the waveform column span renderer.
package wcsr_pkg;

  localparam int COL_W      = 12;
  localparam int ADDR_W     = 12;
  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 13;
  localparam int BAR_W      = 5;
  localparam int HALF_W     = 4;
  localparam int Q8_W       = 16;
  localparam int ROW_W      = 12;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_FRAME_DIM = 4096;
  localparam int QUEUE_DEPTH   = 2;

  localparam int DIV_NUM_W = 27;
  localparam int DIV_DEN_W = 13;

  localparam logic [23:0] SAT_LIMIT = 24'h800000;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPP            = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_SAMPLES = 3'd5;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
  localparam logic [BAR_W-1:0] BAR_WIDTH_RST      = 5'd1;
  localparam logic [Q8_W-1:0]  GAIN_RST           = 16'd256;
  localparam logic [Q8_W-1:0]  SPP_RST            = 16'd256;
  localparam logic [DIM_W-1:0] STORED_SAMPLES_RST = 13'd4096;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_RENDER,
    KIND_BLANK
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] value;
    logic [COL_W-1:0]    column;
  } queue_entry_t;

  typedef struct packed {
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  fh;
    logic [ROW_W-1:0]  mid;
    logic [ROW_W-1:0]  amp;
    logic [BAR_W-1:0]  bw;
    logic [HALF_W-1:0] half;
    logic [Q8_W-1:0]   gain;
    logic [Q8_W-1:0]   spp;
    logic [DIM_W-1:0]  cnt;
  } geom_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DW_START,
    ST_DW_WAIT,
    ST_WINDOW,
    ST_CLAMP,
    ST_OFF_MUL,
    ST_OFF_START,
    ST_OFF_WAIT,
    ST_INDEX,
    ST_READ,
    ST_GAIN,
    ST_SCALE,
    ST_ROW,
    ST_EMIT
  } back_state_t;

endpackage

// File: rtl/wcsr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module wcsr_div
  import wcsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 running;
  logic [CNT_W-1:0]     count;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, q[DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && count == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q       <= num;
      rem     <= '0;
      divisor <= den;
      count   <= CNT_W'(DIV_NUM_W - 1);
    end else if (running) begin
      if (fits) begin
        rem <= DIV_DEN_W'(shifted - {1'b0, divisor});
        q   <= {q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_DEN_W-1:0];
        q   <= {q[DIV_NUM_W-2:0], 1'b0};
      end
      count <= count - CNT_W'(1);
    end
  end

endmodule

// File: rtl/wcsr_front.sv
// Command intake: takes one item, classifies it and hands it to the queue; writes beyond the store are dropped.
module wcsr_front
  import wcsr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       cmd,
  input  logic [ADDR_W-1:0]          sample_addr,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [COL_W-1:0]           column,
  input  logic                       degen,
  input  logic                       q_full,
  output logic                       busy,
  output logic                       push,
  output queue_entry_t               push_entry
);

  logic         hold;
  queue_entry_t entry;
  logic         accept;
  logic         keep;
  kind_t        kind;

  assign busy       = hold & q_full;
  assign push       = hold & ~q_full;
  assign accept     = start & ~busy;
  assign push_entry = entry;

  always_comb begin
    if (cmd == CMD_WRITE) begin
      kind = KIND_WRITE;
      keep = 32'(sample_addr) < SAMPLE_DEPTH;
    end else begin
      kind = degen ? KIND_BLANK : KIND_RENDER;
      keep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (accept) begin
      hold <= keep;
    end else if (push) begin
      hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry.kind   <= kind;
      entry.addr   <= sample_addr;
      entry.value  <= sample_value;
      entry.column <= column;
    end
  end

endmodule

// File: rtl/wcsr_queue.sv
// Short command queue between intake and render engine.
module wcsr_queue
  import wcsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output queue_entry_t head,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: rtl/wcsr_back.sv
// Render engine: sample store, resampling, gain, row mapping and span output.
module wcsr_back
  import wcsr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096
)
(
  input  logic               clk,
  input  logic               rst,
  input  geom_t              geom,
  input  logic               q_empty,
  input  queue_entry_t       head,
  output logic               pop,
  output logic               done,
  output logic               drawn,
  output logic [COORD_W-1:0] x_first,
  output logic [COORD_W-1:0] x_last,
  output logic [COORD_W-1:0] y_top,
  output logic [COORD_W-1:0] y_bottom
);

  localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  back_state_t state;
  back_state_t state_next;

  logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] rdata;

  logic [COL_W-1:0]    column;
  logic                blank;
  logic [DIM_W-1:0]    dw;
  logic [28:0]         prod_w;
  logic [DIM_W-1:0]    wn;
  logic [DIM_W-1:0]    start_pos;
  logic [24:0]         off_prod;
  logic [DIM_W-1:0]    off;
  logic [DIM_W-1:0]    idx;
  logic signed [32:0]  prod_p;
  logic                neg;
  logic [ROW_W-1:0]    scaled;
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    prev_row;
  logic                prev_valid;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;

  logic                 col_out;
  logic [DIM_W-1:0]     dw_m1;
  logic [29:0]          rnd_sum;
  logic [21:0]          rnd;
  logic [DIM_W-1:0]     wn_clamp;
  logic [DIM_W:0]       idx_sum;
  logic [DIM_W-1:0]     idx_clamp;
  logic signed [16:0]   sample_s;
  logic signed [16:0]   gain_s;
  logic [32:0]          mag_full;
  logic [23:0]          mag;
  logic [35:0]          sc_prod;
  logic                 join_prev;
  logic [ROW_W-1:0]     span_top;
  logic [ROW_W-1:0]     span_bot;
  logic [ROW_W-1:0]     top_c;
  logic [DIM_W-1:0]     bot_sum;
  logic [DIM_W-1:0]     bot_c;
  logic [16:0]          x_prod;
  logic [16:0]          x_end;

  wcsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // datapath helpers
  assign col_out  = {1'b0, column} >= dw;
  assign dw_m1    = dw - DIM_W'(1);
  assign rnd_sum  = {1'b0, prod_w} + 30'd128;
  assign rnd      = rnd_sum[29:8];

  always_comb begin
    if (rnd < 22'd2) begin
      wn_clamp = DIM_W'(2);
    end else if (rnd > 22'(geom.cnt)) begin
      wn_clamp = geom.cnt;
    end else begin
      wn_clamp = rnd[DIM_W-1:0];
    end
  end

  assign idx_sum   = {1'b0, start_pos} + {1'b0, off};
  assign idx_clamp = (idx_sum >= {1'b0, geom.cnt}) ? geom.cnt - DIM_W'(1)
                                                   : idx_sum[DIM_W-1:0];

  assign sample_s = {rdata[SAMPLE_W-1], rdata};
  assign gain_s   = $signed({1'b0, geom.gain});
  assign mag_full = prod_p[32] ? 33'(-prod_p) : 33'(prod_p);
  assign mag      = (mag_full > 33'(SAT_LIMIT)) ? SAT_LIMIT : mag_full[23:0];
  assign sc_prod  = 36'(mag) * 36'(geom.amp);

  assign join_prev = (column != '0) && prev_valid;
  assign span_top  = (join_prev && prev_row < row) ? prev_row : row;
  assign span_bot  = (join_prev && prev_row > row) ? prev_row : row;
  assign top_c     = (span_top > ROW_W'(geom.half)) ? span_top - ROW_W'(geom.half) : '0;
  assign bot_sum   = {1'b0, span_bot} + DIM_W'(geom.half);
  assign bot_c     = (bot_sum >= geom.fh) ? geom.fh - DIM_W'(1) : bot_sum;
  assign x_prod    = 17'(column) * 17'(geom.bw);
  assign x_end     = x_prod + 17'(geom.bw) - 17'd1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            KIND_RENDER: state_next = ST_DW_START;
            KIND_BLANK:  state_next = ST_EMIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_DW_START:  state_next = ST_DW_WAIT;
      ST_DW_WAIT:   state_next = div_done ? ST_WINDOW : ST_DW_WAIT;
      ST_WINDOW:    state_next = col_out ? ST_EMIT : ST_CLAMP;
      ST_CLAMP:     state_next = ST_OFF_MUL;
      ST_OFF_MUL:   state_next = ST_OFF_START;
      ST_OFF_START: state_next = (dw > DIM_W'(1)) ? ST_OFF_WAIT : ST_INDEX;
      ST_OFF_WAIT:  state_next = div_done ? ST_INDEX : ST_OFF_WAIT;
      ST_INDEX:     state_next = ST_READ;
      ST_READ:      state_next = ST_GAIN;
      ST_GAIN:      state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_ROW;
      ST_ROW:       state_next = ST_EMIT;
      ST_EMIT:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == ST_IDLE) && !q_empty;
    div_start = (state == ST_DW_START) || (state == ST_OFF_START && dw > DIM_W'(1));
    if (state == ST_DW_START) begin
      div_num = DIV_NUM_W'(geom.fw);
      div_den = DIV_DEN_W'(geom.bw);
    end else begin
      div_num = DIV_NUM_W'({off_prod, 1'b0}) + DIV_NUM_W'(dw_m1);
      div_den = {dw_m1[DIV_DEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_WRITE) begin
      mem[AW'(head.addr)] <= head.value;
    end
    rdata <= mem[AW'(idx)];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        column <= head.column;
        blank  <= head.kind == KIND_BLANK;
      end
      ST_DW_WAIT: begin
        if (div_done) begin
          dw <= div_quot[DIM_W-1:0];
        end
      end
      ST_WINDOW: begin
        blank  <= col_out;
        prod_w <= 29'(dw) * 29'(geom.spp);
      end
      ST_CLAMP: begin
        wn <= wn_clamp;
      end
      ST_OFF_MUL: begin
        off_prod  <= 25'(column) * 25'(wn - DIM_W'(1));
        start_pos <= geom.cnt - wn;
      end
      ST_OFF_START: begin
        off <= '0;
      end
      ST_OFF_WAIT: begin
        if (div_done) begin
          off <= div_quot[DIM_W-1:0];
        end
      end
      ST_INDEX: begin
        idx <= idx_clamp;
      end
      ST_GAIN: begin
        prod_p <= sample_s * gain_s;
      end
      ST_SCALE: begin
        scaled <= sc_prod[34:23];
        neg    <= prod_p[32];
      end
      ST_ROW: begin
        row <= neg ? geom.mid + scaled : geom.mid - scaled;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      prev_row   <= '0;
      prev_valid <= 1'b0;
    end else begin
      done <= state == ST_EMIT;
      if (state == ST_EMIT && !blank) begin
        prev_row   <= row;
        prev_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      if (blank) begin
        drawn    <= 1'b0;
        x_first  <= '0;
        x_last   <= '0;
        y_top    <= '0;
        y_bottom <= '0;
      end else begin
        drawn    <= 1'b1;
        x_first  <= x_prod[COORD_W-1:0];
        x_last   <= x_end[COORD_W-1:0];
        y_top    <= top_c;
        y_bottom <= bot_c[COORD_W-1:0];
      end
    end
  end

endmodule

// File: rtl/waveform_column_span_renderer.sv
// Waveform column span renderer: configuration registers, intake, queue, render engine.
// Writes pass the intake register and a queue slot to the store, one per cycle while no
// render holds the engine. Renders make two divider passes, width then offset (one with a
// single display column); degenerate renders skip to output, off-range columns after the
// first pass. Renders run one at a time; busy rises only when queue and intake are full.
// Results go out on done and cannot be held off; synchronous rst restores all defaults.
module waveform_column_span_renderer
  import wcsr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [ADDR_W-1:0]          sample_addr,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [COL_W-1:0]           column,
  output logic                       done,
  output logic                       drawn,
  output logic [COORD_W-1:0]         x_first,
  output logic [COORD_W-1:0]         x_last,
  output logic [COORD_W-1:0]         y_top,
  output logic [COORD_W-1:0]         y_bottom,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [BAR_W-1:0] bar_width;
  logic [Q8_W-1:0]  gain_q8;
  logic [Q8_W-1:0]  samples_per_pixel_q8;
  logic [DIM_W-1:0] stored_samples;

  geom_t        geom;
  logic         degen;
  logic         q_full;
  logic         q_empty;
  logic         push;
  logic         pop;
  queue_entry_t push_entry;
  queue_entry_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width          <= FRAME_WIDTH_RST;
      frame_height         <= FRAME_HEIGHT_RST;
      bar_width            <= BAR_WIDTH_RST;
      gain_q8              <= GAIN_RST;
      samples_per_pixel_q8 <= SPP_RST;
      stored_samples       <= STORED_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width          <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height         <= cfg_data[DIM_W-1:0];
        REG_BAR_WIDTH:      bar_width            <= cfg_data[BAR_W-1:0];
        REG_GAIN:           gain_q8              <= cfg_data;
        REG_SPP:            samples_per_pixel_q8 <= cfg_data;
        REG_STORED_SAMPLES: stored_samples       <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective geometry
  always_comb begin
    geom.fw   = (frame_width > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : frame_width;
    geom.fh   = (frame_height > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : frame_height;
    geom.bw   = (bar_width == '0) ? BAR_W'(1) : bar_width;
    geom.gain = (gain_q8 == '0) ? GAIN_RST : gain_q8;
    geom.spp  = (samples_per_pixel_q8 == '0) ? SPP_RST : samples_per_pixel_q8;
    geom.cnt  = (32'(stored_samples) > SAMPLE_DEPTH) ? DIM_W'(SAMPLE_DEPTH) : stored_samples;
    geom.mid  = geom.fh[DIM_W-1:1];
    geom.amp  = geom.mid - ROW_W'(geom.bw);
    geom.half = geom.bw[BAR_W-1:1];
    degen     = (geom.fw <= DIM_W'(1)) || (geom.fh == '0) || (geom.cnt <= DIM_W'(1))
             || (geom.mid <= ROW_W'(geom.bw));
  end

  wcsr_front #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .sample_addr  (sample_addr),
    .sample_value (sample_value),
    .column       (column),
    .degen        (degen),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_entry   (push_entry)
  );

  wcsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  wcsr_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .done     (done),
    .drawn    (drawn),
    .x_first  (x_first),
    .x_last   (x_last),
    .y_top    (y_top),
    .y_bottom (y_bottom)
  );

endmodule
